/* design/rcw_pkg.sv */
// Shared types and constants for the Reno congestion window controller.
`default_nettype none

package rcw_pkg;

  // Default sizes of the window and sequence datapaths
  localparam int WINDOW_BITS_DEF = 16;
  localparam int SEQ_BITS_DEF    = 32;

  // Duplicate counter width and saturation value
  localparam int          CNT_BITS = 4;
  localparam logic [3:0]  DUP_MAX  = 4'd15;

  // Window inflation on entry to fast recovery
  localparam int FAST_INFLATE = 3;

  // Configuration register reset values
  localparam logic [15:0] INIT_THR_RESET  = 16'd4096;
  localparam logic [3:0]  DUP_LIMIT_RESET = 4'd3;

  // Configuration register indexes
  localparam logic REG_INIT_THR  = 1'b0;
  localparam logic REG_DUP_LIMIT = 1'b1;

  // Event kind carried on the input tuser
  localparam logic ACT_ACK     = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // Congestion control mode
  typedef enum logic [1:0] {
    MODE_SLOW  = 2'd0,
    MODE_AVOID = 2'd1,
    MODE_FAST  = 2'd2
  } mode_e;

endpackage

`default_nettype wire

/* design/rcw_update.sv */
// Next-state and result logic for one congestion control event.
`default_nettype none

module rcw_update #(
  parameter int WINDOW_BITS = rcw_pkg::WINDOW_BITS_DEF,
  parameter int SEQ_BITS    = rcw_pkg::SEQ_BITS_DEF
) (
  input  logic                          action_i,
  input  logic [31:0]                   ack_number_i,
  input  logic [WINDOW_BITS-1:0]        window_i,
  input  logic [WINDOW_BITS-1:0]        threshold_i,
  input  logic [rcw_pkg::CNT_BITS-1:0]  dup_count_i,
  input  rcw_pkg::mode_e                mode_i,
  input  logic [SEQ_BITS-1:0]           base_i,
  input  logic [3:0]                    dup_limit_i,
  output logic [WINDOW_BITS-1:0]        window_o,
  output logic [WINDOW_BITS-1:0]        threshold_o,
  output logic [rcw_pkg::CNT_BITS-1:0]  dup_count_o,
  output rcw_pkg::mode_e                mode_o,
  output logic [SEQ_BITS-1:0]           base_o,
  output logic                          retransmit_o
);
  import rcw_pkg::*;

  localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);
  localparam logic [WINDOW_BITS:0]   WMAX_X  = {1'b0, {WINDOW_BITS{1'b1}}};

  logic [SEQ_BITS-1:0]    base_inc;
  logic                   ack_match;
  logic [WINDOW_BITS-1:0] win_half;
  logic [WINDOW_BITS-1:0] fast_thr;
  logic [WINDOW_BITS:0]   fast_sum;
  logic [WINDOW_BITS-1:0] fast_win;
  logic [WINDOW_BITS:0]   dbl_raw;
  logic [WINDOW_BITS-1:0] dbl_win;
  logic [WINDOW_BITS:0]   inc_raw;
  logic [WINDOW_BITS-1:0] inc_win;
  logic [WINDOW_BITS-1:0] thr_min1;
  logic [CNT_BITS-1:0]    cnt_inc;
  logic [CNT_BITS-1:0]    lim;

  // Shared arithmetic terms
  always_comb begin
    base_inc  = base_i + SEQ_BITS'(1);
    ack_match = (ack_number_i[SEQ_BITS-1:0] == base_inc);
    win_half  = window_i >> 1;
    fast_thr  = (win_half == '0) ? WIN_ONE : win_half;
    fast_sum  = {1'b0, fast_thr} + (WINDOW_BITS+1)'(FAST_INFLATE);
    fast_win  = (fast_sum > WMAX_X) ? '1 : fast_sum[WINDOW_BITS-1:0];
    dbl_raw   = {window_i, 1'b0};
    dbl_win   = (dbl_raw > WMAX_X) ? '1 : dbl_raw[WINDOW_BITS-1:0];
    inc_raw   = {1'b0, window_i} + (WINDOW_BITS+1)'(1);
    inc_win   = (inc_raw > WMAX_X) ? '1 : inc_raw[WINDOW_BITS-1:0];
    thr_min1  = (threshold_i == '0) ? WIN_ONE : threshold_i;
    cnt_inc   = (dup_count_i < DUP_MAX) ? dup_count_i + CNT_BITS'(1) : dup_count_i;
    lim       = (dup_limit_i == '0) ? CNT_BITS'(1) : dup_limit_i;
  end

  // Event decode and state update
  always_comb begin
    window_o     = window_i;
    threshold_o  = threshold_i;
    dup_count_o  = dup_count_i;
    mode_o       = mode_i;
    base_o       = base_i;
    retransmit_o = 1'b0;
    priority if (action_i == ACT_TIMEOUT) begin
      threshold_o  = win_half;
      window_o     = WIN_ONE;
      dup_count_o  = '0;
      mode_o       = MODE_SLOW;
      retransmit_o = 1'b1;
    end else if (!ack_match) begin
      // duplicate acknowledgement
      if (cnt_inc >= lim) begin
        threshold_o  = fast_thr;
        window_o     = fast_win;
        dup_count_o  = '0;
        mode_o       = MODE_FAST;
        retransmit_o = 1'b1;
      end else begin
        dup_count_o = cnt_inc;
      end
    end else begin
      // new acknowledgement: advance base, grow window or leave fast recovery
      dup_count_o = '0;
      base_o      = base_inc;
      unique case (mode_i)
        MODE_SLOW: begin
          if (dbl_win >= threshold_i) begin
            window_o = thr_min1;
            mode_o   = MODE_AVOID;
          end else begin
            window_o = dbl_win;
          end
        end
        MODE_AVOID: window_o = inc_win;
        MODE_FAST: begin
          window_o = thr_min1;
          mode_o   = MODE_AVOID;
        end
        default: ;  // unused code holds window and mode
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/reno_congestion_window_fsm.sv */
// Top level of the Reno congestion window controller.
//
// Events enter on the s_axis stream: tuser is the event kind (acknowledgement
// or timeout), tdata the acknowledged sequence number. Each event yields one
// result beat on m_axis: tuser flags a retransmit, tdata carries the resend
// point, window, threshold, base and mode after the event.
// An event is captured in an input register; the update logic then runs on
// it and writes the state and the result register together once the result
// register is free, and the result beat is then valid on m_axis. One event
// per cycle is sustained while m_axis does not stall; the limit is the single
// state update per cycle that the window, threshold and base registers allow.
// When m_axis stalls, the result register holds and one further event waits
// in the input register; s_axis_tready drops only when both are full.
// Reset clears both stages, sets window 1, threshold 4096 (clamped to the
// window maximum), base 0, slow start, and loads the register defaults.
// The APB port holds initial_threshold at 0x0 and duplicate_limit at 0x4;
// a written initial_threshold is only stored and read back; it does not set the threshold.
`default_nettype none

module reno_congestion_window_fsm #(
  parameter int WINDOW_BITS = rcw_pkg::WINDOW_BITS_DEF,
  parameter int SEQ_BITS    = rcw_pkg::SEQ_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // event stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // [31:0] ack_number
  input  logic          s_axis_tuser,   // [0] action
  // result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] resend_from, [47:32] window_size, [63:48] threshold_now,
  // [95:64] base_now, [97:96] mode_now, [103:98] zero
  output logic [103:0]  m_axis_tdata,
  output logic          m_axis_tuser    // [0] retransmit
);
  import rcw_pkg::*;

  localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);
  localparam logic [WINDOW_BITS-1:0] WMAX    = '1;
  localparam logic [WINDOW_BITS-1:0] THR_INIT =
      ({16'd0, INIT_THR_RESET} > {32'd0, WMAX}) ? WMAX : WINDOW_BITS'(INIT_THR_RESET);

  // Configuration registers
  logic [15:0] init_thr_q;
  logic [3:0]  dup_limit_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_thr_q  <= INIT_THR_RESET;
      dup_limit_q <= DUP_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_INIT_THR:  init_thr_q  <= pwdata[15:0];
        REG_DUP_LIMIT: dup_limit_q <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INIT_THR:  prdata = {16'd0, init_thr_q};
      REG_DUP_LIMIT: prdata = {28'd0, dup_limit_q};
    endcase
  end

  // Input register and handshake
  logic        in_valid_q;
  logic        in_action_q;
  logic [31:0] in_ack_q;
  logic        out_valid_q;
  logic        step;

  assign step          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= s_axis_tuser;
      in_ack_q    <= s_axis_tdata;
    end
  end

  // Congestion state
  logic [WINDOW_BITS-1:0] window_q, window_d;
  logic [WINDOW_BITS-1:0] thr_q, thr_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  mode_e                  mode_q, mode_d;
  logic [SEQ_BITS-1:0]    base_q, base_d;
  logic                   rtx_d;

  rcw_update #(
    .WINDOW_BITS (WINDOW_BITS),
    .SEQ_BITS    (SEQ_BITS)
  ) u_update (
    .action_i     (in_action_q),
    .ack_number_i (in_ack_q),
    .window_i     (window_q),
    .threshold_i  (thr_q),
    .dup_count_i  (cnt_q),
    .mode_i       (mode_q),
    .base_i       (base_q),
    .dup_limit_i  (dup_limit_q),
    .window_o     (window_d),
    .threshold_o  (thr_d),
    .dup_count_o  (cnt_d),
    .mode_o       (mode_d),
    .base_o       (base_d),
    .retransmit_o (rtx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_ONE;
      thr_q    <= THR_INIT;
      cnt_q    <= '0;
      mode_q   <= MODE_SLOW;
      base_q   <= '0;
    end else if (step) begin
      window_q <= window_d;
      thr_q    <= thr_d;
      cnt_q    <= cnt_d;
      mode_q   <= mode_d;
      base_q   <= base_d;
    end
  end

  // Result register
  logic        out_rtx_q;
  logic [31:0] out_resend_q;
  logic [15:0] out_win_q;
  logic [15:0] out_thr_q;
  logic [31:0] out_base_q;
  logic [1:0]  out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rtx_q    <= rtx_d;
      out_resend_q <= rtx_d ? 32'(base_q) : 32'd0;
      out_win_q    <= 16'(window_d);
      out_thr_q    <= 16'(thr_d);
      out_base_q   <= 32'(base_d);
      out_mode_q   <= mode_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rtx_q;
  assign m_axis_tdata  = {6'd0, out_mode_q, out_base_q, out_thr_q, out_win_q, out_resend_q};

endmodule

`default_nettype wire

/* dv/tb_reno_congestion_window_fsm.sv */
// Self-checking testbench for the Reno congestion window controller.
module tb_reno_congestion_window_fsm;
  import rcw_pkg::*;

  // Result beat fields, in the order they sit on the master stream
  typedef struct packed {
    logic        retx;
    logic [31:0] resend;
    logic [15:0] win;
    logic [15:0] thr;
    logic [31:0] base;
    mode_e       mode;
  } reno_result_t;

  // One directed event; want is used only where typed is set
  typedef struct packed {
    logic         act;
    logic [31:0]  ack;
    logic         typed;
    reno_result_t want;
  } step_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // [31:0] ack_number
  logic         s_axis_tuser = 1'b0; // [0] action
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [31:0] resend_from, [47:32] window_size, [63:48] threshold_now,
  // [95:64] base_now, [97:96] mode_now, [103:98] zero
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;        // [0] retransmit

  reno_congestion_window_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predicted controller state and register copies
  logic [15:0]  cwnd = 16'd1;
  logic [15:0]  ssthresh = INIT_THR_RESET;
  logic [3:0]   dup_cnt = '0;
  mode_e        cc_mode = MODE_SLOW;
  logic [31:0]  snd_base = '0;
  logic [15:0]  cfg_init_thr = INIT_THR_RESET;
  logic [3:0]   cfg_dup_limit = DUP_LIMIT_RESET;

  reno_result_t expected_results [$];
  int unsigned  mismatch_count = 0;
  bit           calm = 1'b0;          // no idling on either side while set
  int unsigned  hold_asked = 0;
  int unsigned  hold_served = 0;
  int unsigned  stall_left = 0;

  // Directed events from reset (limit 3, threshold 4096)
  step_row_t directed_steps [18] = '{
    '{ACT_ACK,     32'd1,          1'b1,
      '{1'b0, 32'd0, 16'd2, 16'd4096, 32'd1, MODE_SLOW}},
    '{ACT_ACK,     32'd2,          1'b0, '0},  // still below threshold
    '{ACT_TIMEOUT, 32'hFFFF_FFFF,  1'b0, '0},  // ack field ignored
    '{ACT_TIMEOUT, 32'd0,          1'b0, '0},  // window 1 -> threshold 0
    '{ACT_ACK,     32'd3,          1'b0, '0},  // threshold 0 -> window 1
    '{ACT_ACK,     32'd4,          1'b0, '0},
    '{ACT_ACK,     32'd0,          1'b0, '0},
    '{ACT_ACK,     32'hFFFF_FFFF,  1'b0, '0},
    '{ACT_ACK,     32'd4,          1'b0, '0},  // third duplicate
    '{ACT_ACK,     32'd5,          1'b0, '0},  // leave fast recovery
    '{ACT_TIMEOUT, 32'd0,          1'b0, '0},
    '{ACT_ACK,     32'd0,          1'b0, '0},
    '{ACT_ACK,     32'd0,          1'b0, '0},
    '{ACT_ACK,     32'd0,          1'b0, '0},  // fast recovery from window 1
    '{ACT_TIMEOUT, 32'h8000_0000,  1'b0, '0},  // timeout in fast recovery
    '{ACT_ACK,     32'd6,          1'b0, '0},
    '{ACT_ACK,     32'd7,          1'b0, '0},
    '{ACT_ACK,     32'd7,          1'b0, '0}
  };

  logic [15:0] thr_settings [5] = '{16'hFFFF, 16'd1, 16'h8000, 16'd4096, 16'h5A5A};
  logic [3:0]  lim_settings [5] = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd7};

  initial forever #5 clk_i = ~clk_i;

  // Reno update for one event; returns the result beat it should produce
  function automatic reno_result_t advance_window(input logic act, input logic [31:0] ack);
    reno_result_t r;
    logic [3:0]   lim;
    logic [16:0]  grown;
    r = '0;
    if (act == ACT_TIMEOUT) begin
      ssthresh = cwnd >> 1;
      cwnd     = 16'd1;
      dup_cnt  = '0;
      cc_mode  = MODE_SLOW;
      r.retx   = 1'b1;
      r.resend = snd_base;
    end else if (ack != snd_base + 32'd1) begin
      // duplicate: limit 0 behaves as 1, counter sticks at its maximum
      lim = (cfg_dup_limit == 4'd0) ? 4'd1 : cfg_dup_limit;
      if (dup_cnt != DUP_MAX) dup_cnt = dup_cnt + 4'd1;
      if (dup_cnt >= lim) begin
        ssthresh = ((cwnd >> 1) == 16'd0) ? 16'd1 : (cwnd >> 1);
        grown    = {1'b0, ssthresh} + 17'(FAST_INFLATE);
        cwnd     = grown[16] ? 16'hFFFF : grown[15:0];
        dup_cnt  = '0;
        cc_mode  = MODE_FAST;
        r.retx   = 1'b1;
        r.resend = snd_base;
      end
    end else begin
      dup_cnt = '0;
      case (cc_mode)
        MODE_SLOW: begin
          grown = {cwnd, 1'b0};
          cwnd  = grown[16] ? 16'hFFFF : grown[15:0];
          if (cwnd >= ssthresh) begin
            cwnd    = (ssthresh == 16'd0) ? 16'd1 : ssthresh;
            cc_mode = MODE_AVOID;
          end
        end
        MODE_AVOID: begin
          grown = {1'b0, cwnd} + 17'd1;
          cwnd  = grown[16] ? 16'hFFFF : grown[15:0];
        end
        MODE_FAST: begin
          cwnd    = (ssthresh == 16'd0) ? 16'd1 : ssthresh;
          cc_mode = MODE_AVOID;
        end
        default: ;
      endcase
      snd_base = snd_base + 32'd1;
    end
    r.win  = cwnd;
    r.thr  = ssthresh;
    r.base = snd_base;
    r.mode = cc_mode;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    mismatch_count++;
  endtask

  // Offer one event beat; called and returning at a falling edge
  task automatic send_event(input logic act, input logic [31:0] ack,
                            input logic typed, input reno_result_t typed_res);
    reno_result_t predicted;
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= ack;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_window(act, ack);
    if (typed) predicted = typed_res;
    expected_results = {expected_results, predicted};
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every result, plus the pipeline depth
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // APB write followed by a readback of the same register
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_INIT_THR) begin
      cfg_init_thr = val[15:0];
      want = {16'd0, cfg_init_thr};
    end else begin
      cfg_dup_limit = val[3:0];
      want = {28'd0, cfg_dup_limit};
    end
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) flag_mismatch("register readback", prdata, want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly in-order acks, with duplicate bursts, stale acks, noise and timeouts
  task automatic random_events(input int unsigned count);
    int unsigned pick;
    int unsigned burst;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_event(ACT_TIMEOUT, $urandom, 1'b0, '0);
      end else if (pick < 68) begin
        send_event(ACT_ACK, snd_base + 32'd1, 1'b0, '0);
      end else if (pick < 76) begin
        burst = cfg_dup_limit + $urandom_range(1);
        repeat (burst) send_event(ACT_ACK, snd_base - $urandom_range(3), 1'b0, '0);
      end else if (pick < 88) begin
        send_event(ACT_ACK, snd_base, 1'b0, '0);
      end else begin
        send_event(ACT_ACK, $urandom, 1'b0, '0);
      end
    end
  endtask

  // Result side: random backpressure, plus long holds on request
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served = hold_served + 1;
      stall_left = 50;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk_i) begin
    reno_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result beat with nothing expected", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.retx)
          flag_mismatch("retransmit", 32'(m_axis_tuser), 32'(want.retx));
        if (m_axis_tdata[31:0] !== want.resend)
          flag_mismatch("resend_from", m_axis_tdata[31:0], want.resend);
        if (m_axis_tdata[47:32] !== want.win)
          flag_mismatch("window_size", 32'(m_axis_tdata[47:32]), 32'(want.win));
        if (m_axis_tdata[63:48] !== want.thr)
          flag_mismatch("threshold_now", 32'(m_axis_tdata[63:48]), 32'(want.thr));
        if (m_axis_tdata[95:64] !== want.base)
          flag_mismatch("base_now", m_axis_tdata[95:64], want.base);
        if (m_axis_tdata[97:96] !== want.mode)
          flag_mismatch("mode_now", 32'(m_axis_tdata[97:96]), 32'(want.mode));
      end
    end
  end

  // Stimulus
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i])
      send_event(directed_steps[i].act, directed_steps[i].ack,
                 directed_steps[i].typed, directed_steps[i].want);

    // count built up under a high limit, then the limit drops below it
    drain_results();
    write_reg(REG_DUP_LIMIT, 32'd15);
    repeat (6) send_event(ACT_ACK, snd_base, 1'b0, '0);
    drain_results();
    write_reg(REG_DUP_LIMIT, 32'd2);
    send_event(ACT_ACK, snd_base, 1'b0, '0);

    // register settings, each followed by random traffic
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_reg(REG_INIT_THR, {16'hA5A5, thr_settings[p]});
      write_reg(REG_DUP_LIMIT, {28'h5A5A5A5, lim_settings[p]});
      calm = (p == 2);
      random_events(30);
      if (p == 1) hold_asked++;     // long stall while events keep coming
      if (p == 3) drain_results();  // sender pause until all results are back
      random_events(50);
    end
    calm = 1'b0;

    // climb in avoidance for a while, then fall back
    repeat (24) send_event(ACT_ACK, snd_base + 32'd1, 1'b0, '0);
    send_event(ACT_TIMEOUT, $urandom, 1'b0, '0);
    random_events(40);

    drain_results();
    if (mismatch_count == 0) begin
      $display("reno_congestion_window_fsm test passed");
    end else begin
      $display("reno_congestion_window_fsm test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("reno_congestion_window_fsm test failed");
    $finish;
  end

endmodule

/* files.f */
design/rcw_pkg.sv
design/rcw_update.sv
design/reno_congestion_window_fsm.sv
dv/tb_reno_congestion_window_fsm.sv
